// ===== design/psrl_pkg.sv =====
`default_nettype none

package psrl_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 9'd1;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PER_WINDOW      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SECONDS      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_EXPIRY_SECONDS = 8'd2;

   localparam logic [7:0]  MAX_PER_WINDOW_RESET      = 8'd5;
   localparam logic [7:0]  WINDOW_SECONDS_RESET      = 8'd1;
   localparam logic [15:0] IDLE_EXPIRY_SECONDS_RESET = 16'd60;

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  address;
      logic [TIME_W-1:0]  last_time;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic clear_wr;
      logic start;
      logic rd_en;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/psrl_ifs.sv =====
`default_nettype none

interface psrl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_address;
   logic [31:0] now_seconds;
   modport source (output valid, output source_address, output now_seconds, input ready);
   modport sink (input valid, input source_address, input now_seconds, output ready);
endinterface

interface psrl_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [8:0] attempt_count;
   modport source (output valid, output allowed, output attempt_count, input ready);
   modport sink (input valid, input allowed, input attempt_count, output ready);
endinterface

interface psrl_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/psrl_controller.sv =====
`default_nettype none

module psrl_controller #(
   parameter int unsigned TABLE_ENTRIES = 64,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire psrl_pkg::dp_status_type status,
   output psrl_pkg::ctl_cmd_type        cmd,
   output logic [IDX_W-1:0]             index
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             idx_last;

   assign idx_last = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign index    = idx_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("accepted item did not start a table scan at entry zero");

   a_scan_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_last) |=> (state_ff == ST_DRAIN))
      else $error("scan did not end after the last entry");

endmodule

`default_nettype wire

// ===== design/psrl_datapath.sv =====
`default_nettype none

module psrl_datapath #(
   parameter int unsigned TABLE_ENTRIES = 64,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psrl_pkg::ctl_cmd_type  cmd,
   input  wire logic [IDX_W-1:0]       index,
   output psrl_pkg::dp_status_type     status,
   input  wire logic [31:0]            source_address,
   input  wire logic [31:0]            now_seconds,
   psrl_rsp_if.source                  rsp,
   psrl_csr_if.sink                    csr
);

   psrl_pkg::entry_type mem [TABLE_ENTRIES];
   psrl_pkg::entry_type mem_q_ff;
   psrl_pkg::entry_type wr_data;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;

   logic [7:0]  max_per_window_ff;
   logic [7:0]  window_seconds_ff;
   logic [15:0] idle_expiry_ff;

   logic [31:0]      addr_ff, now_ff;
   logic             rd_pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             hit_ff, free_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff;
   logic [31:0]      hit_time_ff;
   logic [8:0]       hit_count_ff;

   logic       rsp_valid_ff;
   logic       allowed_ff;
   logic [8:0] count_ff;

   logic [31:0] scan_age;
   logic        scan_expired, scan_live, scan_match;
   logic [31:0] upd_age;
   logic        upd_in_window;
   logic [8:0]  upd_bumped, upd_count;
   logic        upd_allowed;
   logic        load;

   assign scan_age     = now_ff - mem_q_ff.last_time;
   assign scan_expired = mem_q_ff.valid && (scan_age > {16'b0, idle_expiry_ff});
   assign scan_live    = mem_q_ff.valid && !scan_expired;
   assign scan_match   = scan_live && (mem_q_ff.address == addr_ff);

   assign upd_age       = now_ff - hit_time_ff;
   assign upd_in_window = (upd_age < {24'b0, window_seconds_ff});
   assign upd_bumped    = (hit_count_ff == psrl_pkg::COUNT_MAX) ? hit_count_ff
                                                                 : hit_count_ff + 9'd1;

   always_comb begin
      if (hit_ff) begin
         if (upd_in_window) begin
            upd_count   = upd_bumped;
            upd_allowed = !(upd_bumped > {1'b0, max_per_window_ff});
         end else begin
            upd_count   = psrl_pkg::COUNT_ONE;
            upd_allowed = 1'b1;
         end
      end else if (free_ff) begin
         upd_count   = psrl_pkg::COUNT_ONE;
         upd_allowed = 1'b1;
      end else begin
         upd_count   = '0;
         upd_allowed = 1'b1;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp.ready;
   assign load            = cmd.update && status.out_free;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = index;
      end else if (rd_pend_ff && scan_expired) begin
         wr_en         = 1'b1;
         wr_addr       = rd_idx_ff;
         wr_data       = mem_q_ff;
         wr_data.valid = 1'b0;
      end else if (load && (hit_ff || free_ff)) begin
         wr_en             = 1'b1;
         wr_addr           = hit_ff ? hit_idx_ff : free_idx_ff;
         wr_data.valid     = 1'b1;
         wr_data.address   = addr_ff;
         wr_data.last_time = now_ff;
         wr_data.count     = upd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[index];
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= index;
      if (cmd.start) begin
         addr_ff <= source_address;
         now_ff  <= now_seconds;
      end
      if (rd_pend_ff && scan_match) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_time_ff  <= mem_q_ff.last_time;
         hit_count_ff <= mem_q_ff.count;
      end
      if (rd_pend_ff && !scan_live && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (load) begin
         allowed_ff <= upd_allowed;
         count_ff   <= upd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
         if (cmd.start) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (rd_pend_ff) begin
            if (scan_match) begin
               hit_ff <= 1'b1;
            end
            if (!scan_live) begin
               free_ff <= 1'b1;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_per_window_ff <= psrl_pkg::MAX_PER_WINDOW_RESET;
         window_seconds_ff <= psrl_pkg::WINDOW_SECONDS_RESET;
         idle_expiry_ff    <= psrl_pkg::IDLE_EXPIRY_SECONDS_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            psrl_pkg::REG_MAX_PER_WINDOW:      max_per_window_ff <= csr.data[7:0];
            psrl_pkg::REG_WINDOW_SECONDS:      window_seconds_ff <= csr.data[7:0];
            psrl_pkg::REG_IDLE_EXPIRY_SECONDS: idle_expiry_ff    <= csr.data;
            default: begin
            end
         endcase
      end
   end

   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.allowed       = allowed_ff;
   assign rsp.attempt_count = count_ff;

   a_untracked_is_allowed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && count_ff == '0) |-> allowed_ff)
      else $error("untracked item was denied");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(rd_pend_ff && (cmd.update || cmd.clear_wr)))
      else $error("expiry write-back overlaps another table write");

endmodule

`default_nettype wire

// ===== design/per_source_rate_limiter.sv =====
`default_nettype none

// Per-source connection rate limiter over a table of TABLE_ENTRIES tracked IPv4
// sources. Each item is one connection attempt; for each one the block walks the
// whole table once through an entry memory with one read and one write port, dropping
// idle entries and looking up the source, then updates the matching or a free entry,
// if there is one, and returns one item on rsp. The scan reads the table memory one
// entry per cycle; a new item is taken only once the previous result is loaded, and
// may be taken while that result still waits on rsp. After reset the block clears
// every table entry before it accepts items; configuration writes are taken at any
// time and are meant to be issued while idle.

module per_source_rate_limiter #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   psrl_req_if.sink  req_ch,
   psrl_rsp_if.source rsp_ch,
   psrl_csr_if.sink  csr_ch
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   psrl_pkg::ctl_cmd_type   cmd;
   psrl_pkg::dp_status_type status;
   logic [IDX_W-1:0]        index;
   logic                    req_ready;

   assign req_ch.ready = req_ready;

   psrl_controller #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .index     (index)
   );

   psrl_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .index          (index),
      .status         (status),
      .source_address (req_ch.source_address),
      .now_seconds    (req_ch.now_seconds),
      .rsp            (rsp_ch),
      .csr            (csr_ch)
   );

endmodule

`default_nettype wire
